// File: rtl/probe_result_ema_aggregator_top_defines.svh
// Assertion macros for the probe result EMA aggregator.
// No dependencies.
`ifndef PROBE_RESULT_EMA_AGGREGATOR_TOP_DEFINES_SVH
`define PROBE_RESULT_EMA_AGGREGATOR_TOP_DEFINES_SVH
// Property checked on every rising clock edge outside reset.
`define PRA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// Signal never goes unknown outside reset.
`define PRA_KNOWN(lbl, clk, rstn, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !$isunknown(sig)) \
    else $error("unknown value");
`endif

// File: rtl/pra_pkg.sv
// Shared types and constants for the probe result EMA aggregator.
// No dependencies.
`default_nettype none
package pra_pkg;
  localparam int unsigned MaxItems = 16;
  localparam int unsigned FracBits = 4;
  localparam logic [10:0] LossFull = 11'(100 << FracBits);
  localparam logic [1:0] ClsPeer = 2'd1;
  localparam logic [1:0] ClsGw = 2'd2;
  // ceil(2^27 / 10): exact divide by ten for dividends below 2^26
  localparam logic [23:0] DivTenRecip = 24'd13421773;
  localparam int unsigned DivTenShift = 27;

  typedef struct packed {
    logic        is_icmp;
    logic [1:0]  target_class;
    logic        probe_ok;
    logic [10:0] pkt_loss;
    logic [19:0] rtt_ms;
    logic [19:0] jit_ms;
    logic        last_of_cycle;
  } item_t;

  typedef struct packed {
    logic [19:0] gw_rtt_ema;
    logic [19:0] gw_jit_ema;
    logic [10:0] gw_loss_ema;
    logic [19:0] inet_rtt_ema;
    logic [19:0] peer_rtt_ema;
    logic [19:0] inet_jit_ema;
    logic [10:0] inet_loss_ema;
    logic [4:0]  peers_reached;
    logic [6:0]  valid_mask;
  } result_t;

  // Item available from the front queue.
  typedef struct packed {
    logic valid;
  } hs_t;
endpackage
`default_nettype wire

// File: rtl/probe_result_ema_aggregator_top.sv
// Probe result EMA aggregator: front queue, accumulator and cycle-end EMA engine.
// Ordinary items: one per cycle through the back engine while it is idle. A last
// item's result shows after 4 divisions and then 7 EMA steps; the engine takes no
// items until that result is popped. The divider yields one quotient bit per cycle.
// Reset (rst_ni, async, active low) clears queues, sums and unseeds all EMAs.
`default_nettype none
module probe_result_ema_aggregator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        is_icmp_i,
  input  wire logic [1:0]  target_class_i,
  input  wire logic        probe_ok_i,
  input  wire logic [10:0] pkt_loss_i,
  input  wire logic [19:0] rtt_ms_i,
  input  wire logic [19:0] jit_ms_i,
  input  wire logic        last_of_cycle_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [19:0]      gw_rtt_ema_o,
  output logic [19:0]      gw_jit_ema_o,
  output logic [10:0]      gw_loss_ema_o,
  output logic [19:0]      inet_rtt_ema_o,
  output logic [19:0]      peer_rtt_ema_o,
  output logic [19:0]      inet_jit_ema_o,
  output logic [10:0]      inet_loss_ema_o,
  output logic [4:0]       peers_reached_o,
  output logic [6:0]       valid_mask_o
);
  import pra_pkg::*;
  item_t   in_item, q_item;
  hs_t     hs;
  logic    take;
  result_t res;
  logic    rv;

  assign in_item = '{is_icmp_i, target_class_i, probe_ok_i, pkt_loss_i,
                     rtt_ms_i, jit_ms_i, last_of_cycle_i};

  // Front: short queue decoupling arrivals from the engine.
  pra_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .item_o(q_item), .hs_o(hs), .take_i(take)
  );

  // Back: accumulation and cycle-end processing; result held until popped.
  pra_back u_back (
    .clk_i, .rst_ni, .item_i(q_item), .hs_i(hs), .take_o(take),
    .res_o(res), .res_valid_o(rv), .res_take_i(pop)
  );

  assign empty = !rv;
  assign gw_rtt_ema_o = res.gw_rtt_ema;
  assign gw_jit_ema_o = res.gw_jit_ema;
  assign gw_loss_ema_o = res.gw_loss_ema;
  assign inet_rtt_ema_o = res.inet_rtt_ema;
  assign peer_rtt_ema_o = res.peer_rtt_ema;
  assign inet_jit_ema_o = res.inet_jit_ema;
  assign inet_loss_ema_o = res.inet_loss_ema;
  assign peers_reached_o = res.peers_reached;
  assign valid_mask_o = res.valid_mask;
endmodule
`default_nettype wire

// File: rtl/pra_front.sv
// Input queue: two-entry FIFO holding accepted items.
// Depends on pra_pkg.
`default_nettype none
module pra_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire pra_pkg::item_t item_i,
  output pra_pkg::item_t      item_o,
  output pra_pkg::hs_t        hs_o,
  input  wire logic           take_i
);
  import pra_pkg::*;
  `include "probe_result_ema_aggregator_top_defines.svh"

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o = cnt_q[1];
  assign do_push = push_i && !full_o;
  assign do_pop = take_i && cnt_q != 2'd0;
  assign item_o = mem_q[rp_q];
  assign hs_o.valid = cnt_q != 2'd0;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `PRA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `PRA_ASSERT(a_full_no_grow, clk_i, rst_ni, full_o && !do_pop |=> cnt_q == 2'd2)
  `PRA_ASSERT(a_pop_empty, clk_i, rst_ni, cnt_q == 2'd0 |=> cnt_q <= 2'd1)
endmodule
`default_nettype wire

// File: rtl/pra_div.sv
// Restoring divider, one quotient bit per cycle, rounds to nearest.
// Depends on pra_pkg.
`default_nettype none
module pra_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [25:0] num_i,
  input  wire logic [4:0]  den_i,
  output logic             done_o,
  output logic [25:0]      quo_o
);
  import pra_pkg::*;
  logic [25:0] n_q, q_q;
  logic [5:0]  r_q;
  logic [4:0]  d_q;
  logic [4:0]  i_q;
  logic        busy_q;
  logic [5:0]  r_sh;

  assign r_sh = {r_q[4:0], n_q[25]};
  assign quo_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; i_q <= 5'd0;
      n_q <= '0; q_q <= '0; r_q <= '0; d_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; i_q <= 5'd25;
        n_q <= num_i + 26'(den_i[4:1]); d_q <= den_i; r_q <= '0; q_q <= '0;
      end else if (busy_q) begin
        n_q <= {n_q[24:0], 1'b0};
        if (r_sh >= {1'b0, d_q}) begin
          r_q <= r_sh - {1'b0, d_q}; q_q <= {q_q[24:0], 1'b1};
        end else begin
          r_q <= r_sh; q_q <= {q_q[24:0], 1'b0};
        end
        if (i_q == 5'd0) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end else i_q <= i_q - 5'd1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/pra_back.sv
// Back engine: accumulates items, and at cycle end forms means and EMAs.
// Depends on pra_pkg and pra_div.
`default_nettype none
module pra_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pra_pkg::item_t   item_i,
  input  wire pra_pkg::hs_t     hs_i,
  output logic                  take_o,
  output pra_pkg::result_t      res_o,
  output logic                  res_valid_o,
  input  wire logic             res_take_i
);
  import pra_pkg::*;
  `include "probe_result_ema_aggregator_top_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DIV = 5'b00010, S_WAIT = 5'b00100,
    S_EMA = 5'b01000, S_OUT = 5'b10000
  } state_e;
  state_e st_q;

  logic [19:0] e_q [7];  // 0 lp,1 lj,2 ll,3 np,4 nd,5 nj,6 nl
  logic [6:0]  seed_q;
  logic [24:0] s_rtt_q, s_jit_q, s_peer_q;
  logic [14:0] s_loss_q;
  logic [4:0]  c_ok_q, c_pr_q, c_ic_q, c_ls_q;
  logic [10:0] gw_loss_q;
  logic [19:0] gw_ping_q, gw_jit_q;
  logic [1:0]  gw_seen_q;
  logic [19:0] x_q [7];
  logic [6:0]  upd_q;
  logic [1:0]  di_q;
  logic [2:0]  ei_q;
  logic        dstart;
  logic        ddone;
  logic [25:0] dnum, dquo;
  logic [4:0]  dden;
  logic [10:0] loss;
  logic [1:0]  cls;
  logic        idle_take;
  logic [23:0] mix_sum;
  logic [47:0] mix_prod;
  logic [19:0] ema_mix;

  assign loss = (item_i.pkt_loss > LossFull) ? LossFull : item_i.pkt_loss;
  assign cls = (item_i.target_class == 2'd3) ? 2'd0 : item_i.target_class;
  assign idle_take = st_q == S_IDLE && hs_i.valid;
  assign take_o = idle_take;
  assign res_valid_o = st_q == S_OUT;

  always_comb begin
    dnum = '0; dden = c_ok_q;
    unique case (di_q)
      2'd0: begin dnum = 26'(s_rtt_q); dden = c_ok_q; end
      2'd1: begin dnum = 26'(s_jit_q); dden = c_ok_q; end
      2'd2: begin dnum = 26'(s_peer_q); dden = c_pr_q; end
      default: begin dnum = 26'(s_loss_q); dden = c_ls_q; end
    endcase
  end

  pra_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  assign dstart = st_q == S_DIV;
  // round((7*old + 3*new) / 10), divide by ten through the reciprocal
  assign mix_sum = 24'(e_q[ei_q]) * 24'd7 + 24'(x_q[ei_q]) * 24'd3 + 24'd5;
  assign mix_prod = 48'(mix_sum) * 48'(DivTenRecip);
  assign ema_mix = mix_prod[DivTenShift+19:DivTenShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; seed_q <= '0; upd_q <= '0; di_q <= '0; ei_q <= '0;
      s_rtt_q <= '0; s_jit_q <= '0; s_peer_q <= '0; s_loss_q <= '0;
      c_ok_q <= '0; c_pr_q <= '0; c_ic_q <= '0; c_ls_q <= '0;
      gw_loss_q <= '0; gw_ping_q <= '0; gw_jit_q <= '0; gw_seen_q <= '0;
      for (int i = 0; i < 7; i++) begin e_q[i] <= '0; x_q[i] <= '0; end
    end else begin
      unique case (st_q)
        S_IDLE: if (idle_take) begin
          if (item_i.is_icmp) begin
            if (cls == ClsGw) begin
              gw_loss_q <= loss; gw_seen_q[0] <= 1'b1;
              if (item_i.probe_ok) begin
                gw_ping_q <= item_i.rtt_ms; gw_jit_q <= item_i.jit_ms;
                gw_seen_q[1] <= 1'b1;
              end
            end else if (c_ic_q < 5'(MaxItems)) begin
              c_ic_q <= c_ic_q + 5'd1;
              if (!(loss >= LossFull && cls == ClsPeer)) begin
                s_loss_q <= s_loss_q + 15'(loss); c_ls_q <= c_ls_q + 5'd1;
              end
              if (item_i.probe_ok) begin
                s_rtt_q <= s_rtt_q + 25'(item_i.rtt_ms);
                s_jit_q <= s_jit_q + 25'(item_i.jit_ms);
                c_ok_q <= c_ok_q + 5'd1;
                if (cls == ClsPeer) begin
                  c_pr_q <= c_pr_q + 5'd1; s_peer_q <= s_peer_q + 25'(item_i.rtt_ms);
                end
              end
            end
          end
          if (item_i.last_of_cycle) begin
            di_q <= 2'd0; st_q <= S_DIV;
          end
        end
        S_DIV: begin
          st_q <= S_WAIT;
        end
        S_WAIT: if (ddone) begin
          unique case (di_q)
            2'd0: x_q[3] <= dquo[19:0];
            2'd1: x_q[5] <= dquo[19:0];
            2'd2: x_q[4] <= dquo[19:0];
            default: x_q[6] <= dquo[19:0];
          endcase
          if (di_q == 2'd3) begin
            x_q[0] <= gw_ping_q; x_q[1] <= gw_jit_q; x_q[2] <= 20'(gw_loss_q);
            upd_q <= {c_ic_q != 5'd0 && c_ls_q != 5'd0, c_ic_q != 5'd0 && c_ok_q != 5'd0,
                      c_ic_q != 5'd0 && c_pr_q != 5'd0, c_ic_q != 5'd0 && c_ok_q != 5'd0,
                      gw_seen_q[0], gw_seen_q[1], gw_seen_q[1]};
            ei_q <= 3'd0; st_q <= S_EMA;
          end else begin
            di_q <= di_q + 2'd1; st_q <= S_DIV;
          end
        end
        S_EMA: begin
          if (upd_q[ei_q]) begin
            e_q[ei_q] <= seed_q[ei_q] ? ema_mix : x_q[ei_q];
            seed_q[ei_q] <= 1'b1;
          end
          if (ei_q == 3'd6) begin
            st_q <= S_OUT;
          end else ei_q <= ei_q + 3'd1;
        end
        S_OUT: begin
          if (res_take_i) begin
            st_q <= S_IDLE;
            s_rtt_q <= '0; s_jit_q <= '0; s_peer_q <= '0; s_loss_q <= '0;
            c_ok_q <= '0; c_pr_q <= '0; c_ic_q <= '0; c_ls_q <= '0;
            gw_loss_q <= '0; gw_ping_q <= '0; gw_jit_q <= '0; gw_seen_q <= '0;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Result formed from EMAs after the update pass.
  always_comb begin
    res_o = '0;
    if (gw_seen_q[0]) begin
      res_o.gw_rtt_ema = seed_q[0] ? e_q[0] : 20'd0;
      res_o.gw_jit_ema = seed_q[1] ? e_q[1] : 20'd0;
      res_o.gw_loss_ema = e_q[2][10:0];
      res_o.valid_mask[2:0] = {1'b1, seed_q[1], seed_q[0]};
    end
    if (c_ic_q != 5'd0) begin
      res_o.inet_rtt_ema = seed_q[3] ? e_q[3] : 20'd0;
      res_o.peer_rtt_ema = seed_q[4] ? e_q[4] : 20'd0;
      res_o.inet_loss_ema = seed_q[6] ? e_q[6][10:0] : 11'd0;
      res_o.inet_jit_ema = seed_q[5] ? e_q[5] : 20'd0;
      res_o.peers_reached = c_pr_q;
      res_o.valid_mask[6:3] = {1'b1, seed_q[6], seed_q[4], seed_q[3]};
    end
  end

  `PRA_ASSERT(a_onehot, clk_i, rst_ni, $onehot(st_q))
  `PRA_ASSERT(a_no_take_busy, clk_i, rst_ni, st_q != S_IDLE |-> !take_o)
  `PRA_ASSERT(a_out_hold, clk_i, rst_ni, st_q == S_OUT && !res_take_i |=> st_q == S_OUT)
endmodule
`default_nettype wire

// File: sim/probe_result_ema_aggregator_top_tb.sv
// Testbench for the probe result EMA aggregator: drives probe items through the
// push/full queue, predicts cycle-end EMA results and checks them via empty/pop.
// Depends on pra_pkg and probe_result_ema_aggregator_top.
`timescale 1ns / 1ps
`default_nettype none
module probe_result_ema_aggregator_top_tb;
  import pra_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  item_t item_q = '0;
  result_t res;

  // sender / receiver idle rates in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // predictor state
  logic [19:0] ema_np, ema_nj, ema_nd, ema_lp, ema_lj;
  logic [10:0] ema_nl, ema_ll;
  logic [6:0]  seeded;
  logic [63:0] s_rtt, s_jit, s_loss, s_prtt;
  int unsigned n_ok, n_peer, n_icmp, n_loss;
  logic [10:0] g_loss;
  logic [19:0] g_ping, g_jit;
  logic [1:0]  g_seen;

  result_t pending_results[$];
  bit failed = 1'b0;
  int unsigned idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  probe_result_ema_aggregator_top u_top (
    .clk_i, .rst_ni, .push, .full,
    .is_icmp_i(item_q.is_icmp), .target_class_i(item_q.target_class),
    .probe_ok_i(item_q.probe_ok), .pkt_loss_i(item_q.pkt_loss),
    .rtt_ms_i(item_q.rtt_ms), .jit_ms_i(item_q.jit_ms),
    .last_of_cycle_i(item_q.last_of_cycle),
    .empty, .pop,
    .gw_rtt_ema_o(res.gw_rtt_ema), .gw_jit_ema_o(res.gw_jit_ema),
    .gw_loss_ema_o(res.gw_loss_ema), .inet_rtt_ema_o(res.inet_rtt_ema),
    .peer_rtt_ema_o(res.peer_rtt_ema), .inet_jit_ema_o(res.inet_jit_ema),
    .inet_loss_ema_o(res.inet_loss_ema), .peers_reached_o(res.peers_reached),
    .valid_mask_o(res.valid_mask)
  );

  function automatic logic [19:0] ema_step(logic [19:0] prev, bit was_seeded, logic [63:0] x);
    logic [63:0] t;
    if (!was_seeded) return x[19:0];
    t = (64'd7 * prev + 64'd3 * x + 64'd5) / 64'd10;
    return t[19:0];
  endfunction

  function automatic logic [63:0] rounded_mean(logic [63:0] sum, int unsigned n);
    return (sum + n / 2) / n;
  endfunction

  task automatic clear_cycle_sums();
    s_rtt = 0; s_jit = 0; s_loss = 0; s_prtt = 0;
    n_ok = 0; n_peer = 0; n_icmp = 0; n_loss = 0;
    g_loss = 0; g_ping = 0; g_jit = 0; g_seen = 0;
  endtask

  task automatic reset_predictor();
    ema_np = 0; ema_nj = 0; ema_nd = 0; ema_lp = 0; ema_lj = 0;
    ema_nl = 0; ema_ll = 0; seeded = 0;
    clear_cycle_sums();
  endtask

  // Fold one accepted item into the prediction; queue a result on cycle end.
  task automatic predict_aggregate(item_t it);
    logic [10:0] loss;
    logic [1:0] cls;
    result_t r;
    loss = (it.pkt_loss > LossFull) ? LossFull : it.pkt_loss;
    cls = (it.target_class == 2'd3) ? 2'd0 : it.target_class;
    r = '0;
    if (it.is_icmp) begin
      if (cls == ClsGw) begin
        g_loss = loss;
        g_seen[0] = 1'b1;
        if (it.probe_ok) begin
          g_ping = it.rtt_ms; g_jit = it.jit_ms; g_seen[1] = 1'b1;
        end
      end else if (n_icmp < MaxItems) begin
        n_icmp++;
        // dead peers stay out of the loss mean
        if (!(loss >= LossFull && cls == ClsPeer)) begin
          s_loss += loss; n_loss++;
        end
        if (it.probe_ok) begin
          s_rtt += it.rtt_ms; s_jit += it.jit_ms; n_ok++;
          if (cls == ClsPeer) begin
            n_peer++; s_prtt += it.rtt_ms;
          end
        end
      end
    end
    if (!it.last_of_cycle) return;
    if (g_seen[0]) begin
      ema_ll = 11'(ema_step(20'(ema_ll), seeded[2], 64'(g_loss))); seeded[2] = 1'b1;
      if (g_seen[1]) begin
        ema_lp = ema_step(ema_lp, seeded[0], 64'(g_ping)); seeded[0] = 1'b1;
        ema_lj = ema_step(ema_lj, seeded[1], 64'(g_jit)); seeded[1] = 1'b1;
      end
      if (seeded[0]) begin r.valid_mask[0] = 1'b1; r.gw_rtt_ema = ema_lp; end
      if (seeded[1]) begin r.valid_mask[1] = 1'b1; r.gw_jit_ema = ema_lj; end
      r.valid_mask[2] = 1'b1; r.gw_loss_ema = ema_ll;
    end
    if (n_icmp != 0) begin
      if (n_ok != 0) begin
        ema_np = ema_step(ema_np, seeded[3], rounded_mean(s_rtt, n_ok)); seeded[3] = 1'b1;
        ema_nj = ema_step(ema_nj, seeded[5], rounded_mean(s_jit, n_ok)); seeded[5] = 1'b1;
      end
      if (n_peer != 0) begin
        ema_nd = ema_step(ema_nd, seeded[4], rounded_mean(s_prtt, n_peer)); seeded[4] = 1'b1;
      end
      if (n_loss != 0) begin
        ema_nl = 11'(ema_step(20'(ema_nl), seeded[6], rounded_mean(s_loss, n_loss)));
        seeded[6] = 1'b1;
      end
      if (seeded[3]) begin r.valid_mask[3] = 1'b1; r.inet_rtt_ema = ema_np; end
      if (seeded[4]) begin r.valid_mask[4] = 1'b1; r.peer_rtt_ema = ema_nd; end
      if (seeded[6]) begin r.valid_mask[5] = 1'b1; r.inet_loss_ema = ema_nl; end
      if (seeded[5]) r.inet_jit_ema = ema_nj;
      r.peers_reached = 5'(n_peer);
      r.valid_mask[6] = 1'b1;
    end
    pending_results.push_back(r);
    clear_cycle_sums();
  endtask

  // Send one item: optional idle gap, then hold push until accepted.
  // Returns at the falling edge after acceptance with push still high.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    item_q <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    predict_aggregate(it);
    @(negedge clk_i);
  endtask

  // Receiver: random pop stalls, changed on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker and stall watchdog, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: watchdog timeout", $time);
        $display("probe_result_ema_aggregator_top: mismatch");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res);
          failed = 1'b1;
        end else begin
          result_t e;
          e = pending_results.pop_front();
          if (e !== res) begin
            $display("%0t: result mismatch expected %p actual %p", $time, e, res);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic item_t rand_probe(int unsigned pct_last);
    item_t it;
    int unsigned sel;
    it.is_icmp = ($urandom_range(99) < 90);
    it.target_class = 2'($urandom_range(3));
    it.probe_ok = ($urandom_range(99) < 75);
    sel = $urandom_range(9);
    it.pkt_loss = (sel == 0) ? LossFull : (sel == 1) ? 11'($urandom) :
                  (sel < 5) ? 11'd0 : 11'($urandom_range(1600));
    sel = $urandom_range(9);
    it.rtt_ms = (sel == 0) ? 20'hFFFFF : 20'($urandom);
    it.jit_ms = (sel == 1) ? 20'hFFFFF : 20'($urandom_range(sel < 5 ? 4095 : 1048575));
    it.last_of_cycle = ($urandom_range(99) < pct_last);
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    // empty cycle: non-icmp last still emits
    it = '0; it.last_of_cycle = 1'b1; send_item(it);
    // seeding: gateway ok, peer, anchor
    it = '{1'b1, ClsGw, 1'b1, 11'd160, 20'd320, 20'd16, 1'b0}; send_item(it);
    it = '{1'b1, ClsPeer, 1'b1, 11'd0, 20'd500, 20'd33, 1'b0}; send_item(it);
    it = '{1'b1, 2'd0, 1'b1, 11'd17, 20'd777, 20'd5, 1'b1}; send_item(it);
    // max fields, class three, saturated loss, dead peer
    it = '{1'b1, 2'd3, 1'b1, 11'h7FF, 20'hFFFFF, 20'hFFFFF, 1'b0}; send_item(it);
    it = '{1'b1, ClsPeer, 1'b0, 11'h7FF, 20'hFFFFF, 20'hFFFFF, 1'b0}; send_item(it);
    it = '{1'b1, ClsPeer, 1'b1, LossFull, 20'hFFFFF, 20'h0, 1'b0}; send_item(it);
    it = '{1'b1, ClsGw, 1'b0, 11'h7FF, 20'h0, 20'h0, 1'b1}; send_item(it);
    // gateway only cycle, non-icmp noise
    it = '{1'b0, ClsPeer, 1'b1, 11'd5, 20'd9, 20'd9, 1'b0}; send_item(it);
    it = '{1'b1, ClsGw, 1'b1, 11'd0, 20'd0, 20'hFFFFF, 1'b1}; send_item(it);
    // too many items in one cycle
    for (int i = 0; i < 18; i++) begin
      it = '{1'b1, ClsPeer, 1'b1, 11'd100, 20'(1000 + i), 20'd7, 1'(i == 17)};
      send_item(it);
    end
  endtask

  task automatic test_random(int unsigned n);
    item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it = rand_probe(10);
      if (i == n - 1) it.last_of_cycle = 1'b1;
      send_item(it);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    reset_predictor();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 20; recv_idle_pct = 63;
    test_directed();
    test_random(475);
    send_idle_pct = 63; recv_idle_pct = 20;
    test_random(475);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(475);
    drain();
    if (!failed) $display("probe_result_ema_aggregator_top: match");
    else $display("probe_result_ema_aggregator_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
